[src/sad_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the signed integer ALU with saturating divide.
// Used by sad_div_pipe and signed_integer_alu_sat_div; depends on nothing.
package sad_pkg;

  localparam int WIDTH = 64;
  localparam int HALF  = (WIDTH + 1) / 2;

  typedef logic [WIDTH-1:0]  word_t;
  typedef logic [2*HALF-1:0] prod_t;
  typedef logic [HALF-1:0]   half_t;

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_NEG     = 4'd4,
    CMD_ABS     = 4'd5,
    CMD_XOR     = 4'd6,
    CMD_GEQ     = 4'd7,
    CMD_EQUAL   = 4'd8,
    CMD_IS_ZERO = 4'd9,
    CMD_SELECT  = 4'd10
  } cmd_t;

  localparam word_t WORD_MIN = word_t'(1) << (WIDTH - 1);
  localparam word_t WORD_MAX = ~WORD_MIN;

  typedef struct packed {
    logic  is_div;
    logic  neg;
    word_t rem;
    word_t dq;
    word_t d;
    word_t res;
    logic  flag;
  } div_stage_t;

endpackage

[src/sad_div_pipe.sv]
`timescale 1ns / 1ps
// Restoring divider pipeline, one quotient bit per stage, WIDTH stages.
// Other results ride along unchanged. Depends on sad_pkg.
module sad_div_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  sad_pkg::div_stage_t in_stage,
  output logic                out_vld,
  output sad_pkg::div_stage_t out_stage
);

  sad_pkg::div_stage_t stage [sad_pkg::WIDTH];
  sad_pkg::div_stage_t stage_next [sad_pkg::WIDTH];
  logic [sad_pkg::WIDTH-1:0] vld;

  always_comb begin
    sad_pkg::div_stage_t p;
    logic [sad_pkg::WIDTH:0] trial;
    logic [sad_pkg::WIDTH:0] diff;
    logic ge;
    for (int k = 0; k < sad_pkg::WIDTH; k++) begin
      p = (k == 0) ? in_stage : stage[(k == 0) ? 0 : k - 1];
      trial = {p.rem, p.dq[sad_pkg::WIDTH-1]};
      diff = trial - {1'b0, p.d};
      ge = (trial >= {1'b0, p.d});
      stage_next[k] = p;
      stage_next[k].rem = ge ? diff[sad_pkg::WIDTH-1:0] : trial[sad_pkg::WIDTH-1:0];
      stage_next[k].dq = {p.dq[sad_pkg::WIDTH-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[sad_pkg::WIDTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < sad_pkg::WIDTH; k++) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  assign out_vld   = vld[sad_pkg::WIDTH-1];
  assign out_stage = stage[sad_pkg::WIDTH-1];

endmodule

[src/signed_integer_alu_sat_div.sv]
`timescale 1ns / 1ps
// Top level of the pipelined signed integer ALU with saturating divide.
// Depends on sad_pkg and sad_div_pipe.
//
// Usage: an input beat carries command, operand_a, operand_b and select_bit
// on the in channel (in_valid/in_ready). Each beat gives exactly one output
// beat with value and flag on the out channel (out_valid/out_ready), in order.
// The pipeline has three front stages for operand capture, partial products
// and the product sum, one stage per quotient bit in the restoring divider,
// and one stage for sign and saturation. Every command takes the same path,
// so a new beat is taken every cycle unless the output stage is stalled.
// The whole pipeline advances together; when the output beat is not taken,
// every stage holds and in_ready drops until out_ready returns.
// Synchronous reset clears all valid bits; data registers are not reset.
module signed_integer_alu_sat_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  input  logic        select_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] value,
  output logic        flag
);

  logic en;

  logic s0_vld, s1_vld, s2_vld;
  logic [3:0] s0_cmd, s1_cmd;
  sad_pkg::word_t s0_a, s0_b;
  logic s0_sel;

  sad_pkg::word_t s1_ma, s1_mb, s1_res;
  logic s1_neg, s1_flag;
  sad_pkg::prod_t s1_ll, s1_lh, s1_hl;

  sad_pkg::div_stage_t s2_stage;
  logic dv_vld;
  sad_pkg::div_stage_t dv_stage;

  logic fin_vld;
  sad_pkg::word_t fin_res;
  logic fin_flag;

  sad_pkg::word_t s1_res_next, s0_ma, s0_mb, fin_res_next;
  logic s1_flag_next;
  sad_pkg::half_t a_lo, a_hi, b_lo, b_hi;
  sad_pkg::prod_t mul_sum;

  assign en       = !fin_vld || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld  <= 1'b0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      fin_vld <= 1'b0;
    end else if (en) begin
      s0_vld  <= in_valid;
      s1_vld  <= s0_vld;
      s2_vld  <= s1_vld;
      fin_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cmd <= command;
      s0_a   <= operand_a[sad_pkg::WIDTH-1:0];
      s0_b   <= operand_b[sad_pkg::WIDTH-1:0];
      s0_sel <= select_bit;
    end
  end

  always_comb begin
    s0_ma = s0_a[sad_pkg::WIDTH-1] ? sad_pkg::word_t'(-s0_a) : s0_a;
    s0_mb = s0_b[sad_pkg::WIDTH-1] ? sad_pkg::word_t'(-s0_b) : s0_b;
    a_lo  = s0_a[sad_pkg::HALF-1:0];
    b_lo  = s0_b[sad_pkg::HALF-1:0];
    a_hi  = sad_pkg::half_t'(s0_a >> sad_pkg::HALF);
    b_hi  = sad_pkg::half_t'(s0_b >> sad_pkg::HALF);
    s1_res_next  = '0;
    s1_flag_next = 1'b0;
    case (s0_cmd)
      sad_pkg::CMD_ADD:     s1_res_next = s0_a + s0_b;
      sad_pkg::CMD_SUB:     s1_res_next = s0_a - s0_b;
      sad_pkg::CMD_NEG:     s1_res_next = sad_pkg::word_t'(-s0_a);
      sad_pkg::CMD_ABS:     s1_res_next = s0_ma;
      sad_pkg::CMD_XOR:     s1_res_next = s0_a ^ s0_b;
      sad_pkg::CMD_GEQ:     s1_flag_next = ($signed(s0_a) >= $signed(s0_b));
      sad_pkg::CMD_EQUAL:   s1_flag_next = (s0_a == s0_b);
      sad_pkg::CMD_IS_ZERO: s1_flag_next = (s0_a == '0);
      sad_pkg::CMD_SELECT:  s1_res_next = s0_sel ? s0_a : s0_b;
      default:              s1_res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd  <= s0_cmd;
      s1_ma   <= s0_ma;
      s1_mb   <= s0_mb;
      s1_neg  <= s0_a[sad_pkg::WIDTH-1] ^ s0_b[sad_pkg::WIDTH-1];
      s1_res  <= s1_res_next;
      s1_flag <= s1_flag_next;
      s1_ll   <= a_lo * b_lo;
      s1_lh   <= a_lo * b_hi;
      s1_hl   <= a_hi * b_lo;
    end
  end

  assign mul_sum = s1_ll + ((s1_lh + s1_hl) << sad_pkg::HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_stage.is_div <= (s1_cmd == sad_pkg::CMD_DIV);
      s2_stage.neg    <= s1_neg;
      s2_stage.rem    <= '0;
      s2_stage.dq     <= s1_ma;
      s2_stage.d      <= s1_mb;
      s2_stage.res    <= (s1_cmd == sad_pkg::CMD_MUL) ?
                         sad_pkg::word_t'(mul_sum) : s1_res;
      s2_stage.flag   <= s1_flag;
    end
  end

  sad_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (s2_vld),
    .in_stage  (s2_stage),
    .out_vld   (dv_vld),
    .out_stage (dv_stage)
  );

  always_comb begin
    fin_res_next = dv_stage.res;
    if (dv_stage.is_div) begin
      if (dv_stage.dq[sad_pkg::WIDTH-1]) begin
        fin_res_next = dv_stage.neg ? sad_pkg::WORD_MIN : sad_pkg::WORD_MAX;
      end else begin
        fin_res_next = dv_stage.neg ? sad_pkg::word_t'(-dv_stage.dq) : dv_stage.dq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res  <= fin_res_next;
      fin_flag <= dv_stage.flag;
    end
  end

  assign out_valid = fin_vld;
  assign value     = 64'($signed(fin_res));
  assign flag      = fin_flag;

  a_flag_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag |-> value == 64'sd0)
    else $error("flag set with nonzero value");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s0_vld)
    else $error("accepted beat missing from first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s0_vld) && $stable(s2_vld) && $stable(dv_vld))
    else $error("pipeline moved during stall");

endmodule
